// File: hdl/kcl_pkg.sv
// Package for the k-mer coverage lookup block: sizes, codes and helpers.
package kcl_pkg;
    localparam int TABLE_ENTRIES   = 65536;
    localparam int MAX_KMER_LENGTH = 31;
    localparam int ADDR_W  = $clog2(TABLE_ENTRIES);
    localparam int FILL_W  = ADDR_W + 1;
    localparam int KEY_W   = 62;
    localparam int CNT_W   = 32;
    localparam int LEN_W   = 5;
    localparam int POS_W   = 32;
    localparam int SLOT_W  = 1 + KEY_W + CNT_W;

    localparam logic [1:0] ST_COVERAGE = 2'd0;
    localparam logic [1:0] ST_STORED   = 2'd1;
    localparam logic [1:0] ST_DUP      = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_BASE = 1'b1;

    localparam logic [1:0] CFG_KMER_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_FORWARD_ONLY = 2'd1;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
    } slot_t;

    // ASCII base to 2-bit code; bit 2 set for anything else
    function automatic logic [2:0] base_code(input logic [7:0] c);
        logic [2:0] r;
        begin
            case (c)
                8'h41, 8'h61: r = 3'd0;
                8'h43, 8'h63: r = 3'd1;
                8'h47, 8'h67: r = 3'd2;
                8'h54, 8'h74: r = 3'd3;
                default:      r = 3'd4;
            endcase
            return r;
        end
    endfunction
endpackage

// File: hdl/kmer_coverage_lookup.sv
// Top level: k-mer count table with rolling canonical coverage lookup.
//
// Input channel (s_valid/s_ready) carries requests: action 0 loads one
// (entry_kmer, entry_count) pair into a linear-probed hash table, action 1
// feeds one ASCII base. Loads always give one result (stored, duplicate
// or full). Bases give one coverage result from the k-th base of a
// sequence on, with forward, reverse-complement and total counts.
// One request is handled at a time. The table lives in one single-port
// memory; each probe passes S_RD (address) and S_CHK (registered read data).
// A base is accepted in S_IDLE, probes the forward and then the reverse
// chain (forward only with forward_only) and ends in the output register;
// an invalid k-mer goes straight to the output register, and before the
// k-th base no result is given. A load is accepted, probes its chain,
// passes S_WR when the key is stored, and ends in the output register.
// After reset the memory is swept clear, one slot a cycle, across all
// TABLE_ENTRIES (65536) slots; s_ready stays low meanwhile, while
// configuration writes are taken as ever.
// The result sits in an output register; if the receiver stalls the
// block holds it and takes no further request until it is taken.
// Configuration: cfg_we, cfg_index, cfg_data; the user must write them only when idle; the block does not enforce it.
module kmer_coverage_lookup import kcl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [LEN_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_action,
    input  logic [7:0]       s_base_char,
    input  logic             s_seq_start,
    input  logic [KEY_W-1:0] s_entry_kmer,
    input  logic [CNT_W-1:0] s_entry_count,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [POS_W-1:0] m_position,
    output logic             m_kmer_valid,
    output logic [CNT_W-1:0] m_forward_count,
    output logic [CNT_W-1:0] m_reverse_count,
    output logic [CNT_W:0]   m_total_count
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    slot_t mem [TABLE_ENTRIES];
    slot_t rd_q;

    logic [2:0]        state_reg;
    logic [LEN_W-1:0]  klen_reg;
    logic              fwd_only_reg;
    logic [KEY_W-1:0]  fwin_reg, rwin_reg;
    logic [LEN_W-1:0]  run_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [FILL_W-1:0] stored_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [FILL_W-1:0] probes_reg;   // probes done on current chain
    logic              is_load_reg, rev_phase_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CNT_W-1:0]  cnt_reg, fcnt_reg;
    logic              we;
    slot_t             wdata;

    // effective k
    logic [LEN_W-1:0] k_eff;
    assign k_eff = (klen_reg == '0) ? LEN_W'(1) : klen_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[addr_reg] <= wdata;
        rd_q <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            klen_reg <= LEN_W'(MAX_KMER_LENGTH);
            fwd_only_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case ({1'b0, cfg_index})
                CFG_KMER_LENGTH:  klen_reg <= cfg_data;
                CFG_FORWARD_ONLY: fwd_only_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    // rolling window update for an incoming base
    logic [2:0]        bc;
    logic [5:0]        hi;
    logic [KEY_W-1:0]  fm, fw0, rw0, fw1, rw1;
    logic [LEN_W-1:0]  run0, run1;
    logic [POS_W-1:0]  pos0, pos1;
    always_comb begin
        bc   = base_code(s_base_char);
        hi   = 6'({k_eff, 1'b0} - 6'd2);
        fm   = (KEY_W'(1) << hi) - KEY_W'(1);
        fw0  = s_seq_start ? '0 : fwin_reg;
        rw0  = s_seq_start ? '0 : rwin_reg;
        run0 = s_seq_start ? '0 : run_reg;
        pos0 = s_seq_start ? '0 : pos_reg;
        if (!bc[2]) begin
            fw1  = ((fw0 & fm) << 2) | KEY_W'(bc[1:0]);
            rw1  = ((rw0 >> 2) & fm) | (KEY_W'(bc[1:0] ^ 2'd3) << hi);
            run1 = (run0 == LEN_W'(MAX_KMER_LENGTH)) ? run0 : run0 + LEN_W'(1);
        end else begin
            fw1 = fw0; rw1 = rw0; run1 = '0;
        end
        pos1 = (pos0 == '1) ? pos0 : pos0 + POS_W'(1);
    end

    logic             hit, empty;
    logic [CNT_W-1:0] hit_cnt;
    assign hit     = rd_q.used && (rd_q.key == key_reg);
    assign empty   = !rd_q.used;
    assign hit_cnt = hit ? rd_q.count : '0;

    // memory write: clearing sweep, then stored entries
    always_comb begin
        we = 1'b0;
        wdata = '0;
        unique case (state_reg)
            S_CLEAR: we = 1'b1;
            S_WR: begin
                we = 1'b1;
                wdata.used = 1'b1; wdata.key = key_reg; wdata.count = cnt_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            addr_reg <= '0;
            fwin_reg <= '0; rwin_reg <= '0; run_reg <= '0; pos_reg <= '0;
            stored_reg <= '0;
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    if (addr_reg == '1) state_reg <= S_IDLE;
                end
                S_IDLE: if (s_valid) begin
                    is_load_reg <= (s_action == ACT_LOAD);
                    rev_phase_reg <= 1'b0;
                    probes_reg <= '0;
                    m_status <= ST_COVERAGE;
                    m_position <= '0; m_kmer_valid <= 1'b0;
                    m_forward_count <= '0; m_reverse_count <= '0;
                    m_total_count <= '0;
                    if (s_action == ACT_LOAD) begin
                        key_reg <= s_entry_kmer; cnt_reg <= s_entry_count;
                        addr_reg <= s_entry_kmer[ADDR_W-1:0];
                        state_reg <= S_RD;
                    end else begin
                        fwin_reg <= fw1; rwin_reg <= rw1;
                        run_reg <= run1; pos_reg <= pos1;
                        key_reg <= fw1;
                        addr_reg <= fw1[ADDR_W-1:0];
                        m_position <= pos1 - POS_W'(k_eff) + POS_W'(1);
                        if (pos1 < POS_W'(k_eff)) state_reg <= S_IDLE;
                        else if (run1 >= k_eff) begin
                            m_kmer_valid <= 1'b1;
                            state_reg <= S_RD;
                        end else state_reg <= S_OUT;
                    end
                end
                S_RD: state_reg <= S_CHK;
                S_CHK: begin
                    if (is_load_reg) begin
                        if (hit) begin
                            m_status <= ST_DUP; state_reg <= S_OUT;
                        end else if (empty) begin
                            if (stored_reg >= FILL_W'(TABLE_ENTRIES)) begin
                                m_status <= ST_FULL; state_reg <= S_OUT;
                            end else begin
                                m_status <= ST_STORED;
                                stored_reg <= stored_reg + FILL_W'(1);
                                state_reg <= S_WR;
                            end
                        end else if (probes_reg + FILL_W'(1) ==
                                     FILL_W'(TABLE_ENTRIES)) begin
                            m_status <= ST_FULL; state_reg <= S_OUT;
                        end else begin
                            probes_reg <= probes_reg + FILL_W'(1);
                            addr_reg <= addr_reg + ADDR_W'(1);
                            state_reg <= S_RD;
                        end
                    end else begin
                        if (hit || empty || (probes_reg + FILL_W'(1) ==
                                             FILL_W'(TABLE_ENTRIES))) begin
                            if (!rev_phase_reg) begin
                                fcnt_reg <= hit_cnt;
                                m_forward_count <= hit_cnt;
                                if (fwd_only_reg) begin
                                    m_total_count <= {1'b0, hit_cnt};
                                    state_reg <= S_OUT;
                                end else begin
                                    rev_phase_reg <= 1'b1;
                                    probes_reg <= '0;
                                    key_reg <= rwin_reg;
                                    addr_reg <= rwin_reg[ADDR_W-1:0];
                                    state_reg <= S_RD;
                                end
                            end else begin
                                m_reverse_count <= hit_cnt;
                                m_total_count <= {1'b0, fcnt_reg} + {1'b0, hit_cnt};
                                state_reg <= S_OUT;
                            end
                        end else begin
                            probes_reg <= probes_reg + FILL_W'(1);
                            addr_reg <= addr_reg + ADDR_W'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                S_WR: state_reg <= S_OUT;
                S_OUT: if (m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hdl/kcl_checker.sv
// Port-level checker for the k-mer coverage lookup, bound to the top level.
module kcl_checker import kcl_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [1:0]       m_status,
    input logic             m_kmer_valid,
    input logic [CNT_W-1:0] m_forward_count,
    input logic [CNT_W-1:0] m_reverse_count,
    input logic [CNT_W:0]   m_total_count
);
    // one request in flight: no new request while a result is shown
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("request taken with result pending");
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_total_count ==
            {1'b0, m_forward_count} + {1'b0, m_reverse_count})
        else $error("total mismatch");
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_COVERAGE && !m_kmer_valid) |->
            m_total_count == '0) else $error("invalid k-mer with counts");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_total_count))
        else $error("result dropped while stalled");
    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (s_ready && !m_valid))
        else $error("not ready after result taken");
endmodule

bind kmer_coverage_lookup kcl_checker u_kcl_checker (.*);
